// ===== hdl/cipm_pkg.sv =====
package cipm_pkg;

  // fixed field widths
  localparam int unsigned SYMBOL_W    = 8;
  localparam int unsigned POS_PORT_W  = 32;
  localparam int unsigned COUNT_W     = 32;
  localparam int unsigned LEN_W       = 5;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned WORD_BYTES  = 8;

  // ascii letter folding bounds
  localparam logic [SYMBOL_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [SYMBOL_W-1:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [SYMBOL_W-1:0] CASE_OFFSET  = 8'h20;

  // configuration register map
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_PATTERN_LOW    = 2'd0,
    CFG_PATTERN_HIGH   = 2'd1,
    CFG_PATTERN_LENGTH = 2'd2,
    CFG_FIRST_ONLY     = 2'd3
  } cfg_reg_e;

  // fold lower case ascii letters to upper case
  function automatic logic [SYMBOL_W-1:0] fold_char(input logic [SYMBOL_W-1:0] c);
    if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      return c - CASE_OFFSET;
    end
    return c;
  endfunction

endpackage

// ===== hdl/cipm_in_if.sv =====
interface cipm_in_if
  import cipm_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [SYMBOL_W-1:0] symbol;
  logic                last;

  modport source (output valid, output symbol, output last, input ready);
  modport sink   (input valid, input symbol, input last, output ready);
endinterface

// ===== hdl/cipm_out_if.sv =====
interface cipm_out_if
  import cipm_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic                  match;
  logic [POS_PORT_W-1:0] match_position;
  logic [COUNT_W-1:0]    match_count;
  logic                  sequence_end;
  logic                  first_found;
  logic [POS_PORT_W-1:0] first_position;

  modport source (
    output valid, output match, output match_position, output match_count,
    output sequence_end, output first_found, output first_position,
    input ready
  );
  modport sink (
    input valid, input match, input match_position, input match_count,
    input sequence_end, input first_found, input first_position,
    output ready
  );
endinterface

// ===== hdl/case_insensitive_pattern_match.sv =====
// Case-insensitive pattern matcher over a character stream.
// in_i takes one symbol per transfer; last closes the sequence and restarts
// positions, window fill and the match count for the next one.
// out_o gives exactly one result per input transfer, in order: match pulse,
// start position of the match, saturating match count, sequence_end echo,
// first_found and first_position.
// Pattern, length and first-only mode come in through the cfg write port;
// the user must write them only while the block is idle, which the block
// itself does not enforce. Each input transfer passes the symbol register
// with window shift, then the compare and the result register, before its
// result is offered. Throughput: one item per cycle while out_o is ready;
// the 16-byte parallel window compare and the count update both fit between
// the symbol register and the result register.
// A stalled receiver holds the result register; one more item waits in the
// symbol stage, after which in_i.ready drops until out_o moves again.
// Reset clears the pipeline, the window, all sequence state and loads the
// register defaults (zero pattern, length one, first-only off).
module case_insensitive_pattern_match
  import cipm_pkg::*;
#(
  parameter int unsigned MAX_PATTERN   = 16,
  parameter int unsigned POSITION_BITS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  cipm_in_if.sink                in_i,
  cipm_out_if.source             out_o
);

  localparam int unsigned FILL_W    = $clog2(MAX_PATTERN + 1);
  localparam int unsigned WIN_IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  // configuration
  logic [SYMBOL_W-1:0] pat_q [MAX_PATTERN];
  logic [LEN_W-1:0]    len_q;
  logic                first_only_q;

  // window and sequence position, updated at input transfer
  logic [SYMBOL_W-1:0]      win_q [MAX_PATTERN];
  logic [FILL_W-1:0]        fill_q, fill_inc;
  logic [POSITION_BITS-1:0] idx_q;

  // symbol stage
  logic                     s1_valid_q;
  logic                     s1_last_q;
  logic [FILL_W-1:0]        s1_fill_q;
  logic [POSITION_BITS-1:0] s1_idx_q;

  // per-sequence match state
  logic [COUNT_W-1:0]       count_q, count_d;
  logic                     found_q, found_d;
  logic [POSITION_BITS-1:0] first_q, first_d;

  // result register
  logic                     out_valid_q;
  logic                     res_match_q;
  logic [POSITION_BITS-1:0] res_pos_q;
  logic [COUNT_W-1:0]       res_count_q;
  logic                     res_end_q;
  logic                     res_found_q;
  logic [POSITION_BITS-1:0] res_first_q;

  logic in_xfer, s1_adv;
  logic len_ok, fill_ok, hit_raw, hit;
  logic [MAX_PATTERN-1:0]   byte_ok;
  logic [LEN_W-1:0]         pat_sel [MAX_PATTERN];
  logic [POSITION_BITS-1:0] start;

  // handshake
  assign s1_adv  = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_xfer = in_i.valid && in_i.ready;

  // configuration writes, pattern stored folded
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
        pat_q[k] <= '0;
      end
      len_q        <= LEN_W'(1);
      first_only_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_PATTERN_LOW: begin
          for (int k = 0; k < MAX_PATTERN; k++) begin
            if (k < WORD_BYTES) begin
              pat_q[k] <= fold_char(cfg_data_i[SYMBOL_W*(k & 7) +: SYMBOL_W]);
            end
          end
        end
        CFG_PATTERN_HIGH: begin
          for (int k = 0; k < MAX_PATTERN; k++) begin
            if (k >= WORD_BYTES) begin
              pat_q[k] <= fold_char(cfg_data_i[SYMBOL_W*(k & 7) +: SYMBOL_W]);
            end
          end
        end
        CFG_PATTERN_LENGTH: len_q        <= cfg_data_i[LEN_W-1:0];
        CFG_FIRST_ONLY:     first_only_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // saturating window fill
  assign fill_inc = (fill_q == FILL_W'(MAX_PATTERN)) ? fill_q : fill_q + FILL_W'(1);

  // symbol stage: shift window, track fill and index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < MAX_PATTERN; j++) begin
        win_q[j] <= '0;
      end
      fill_q     <= '0;
      idx_q      <= '0;
      s1_valid_q <= 1'b0;
      s1_last_q  <= 1'b0;
      s1_fill_q  <= '0;
      s1_idx_q   <= '0;
    end else begin
      if (in_xfer) begin
        for (int j = MAX_PATTERN - 1; j > 0; j--) begin
          win_q[j] <= win_q[j-1];
        end
        win_q[0]  <= fold_char(in_i.symbol);
        s1_last_q <= in_i.last;
        s1_fill_q <= fill_inc;
        s1_idx_q  <= idx_q;
        fill_q    <= in_i.last ? '0 : fill_inc;
        idx_q     <= in_i.last ? '0 : idx_q + POSITION_BITS'(1);
      end
      if (in_xfer) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  // window compare against the pattern, newest symbol meets its last byte
  always_comb begin
    for (int j = 0; j < MAX_PATTERN; j++) begin
      pat_sel[j] = len_q - LEN_W'(1) - LEN_W'(j);
      byte_ok[j] = (LEN_W'(j) >= len_q) ||
                   (win_q[j] == pat_q[pat_sel[j][WIN_IDX_W-1:0]]);
    end
  end

  assign len_ok  = (len_q != '0) && (len_q <= LEN_W'(MAX_PATTERN));
  assign fill_ok = LEN_W'(s1_fill_q) >= len_q;
  assign hit_raw = len_ok && fill_ok && (&byte_ok);
  assign hit     = hit_raw && !(first_only_q && found_q);
  assign start   = s1_idx_q - (POSITION_BITS'(len_q) - POSITION_BITS'(1));

  // match count and first match bookkeeping
  always_comb begin
    count_d = count_q;
    found_d = found_q;
    first_d = first_q;
    if (hit) begin
      if (count_q != '1) begin
        count_d = count_q + COUNT_W'(1);
      end
      if (!found_q) begin
        found_d = 1'b1;
        first_d = start;
      end
    end
  end

  // result register and sequence state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      found_q     <= 1'b0;
      first_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        count_q     <= s1_last_q ? '0 : count_d;
        found_q     <= s1_last_q ? 1'b0 : found_d;
        first_q     <= s1_last_q ? '0 : first_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      res_match_q <= hit;
      res_pos_q   <= hit ? start : '0;
      res_count_q <= count_d;
      res_end_q   <= s1_last_q;
      res_found_q <= found_d;
      res_first_q <= first_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.match          = res_match_q;
  assign out_o.match_position = POS_PORT_W'(res_pos_q);
  assign out_o.match_count    = res_count_q;
  assign out_o.sequence_end   = res_end_q;
  assign out_o.first_found    = res_found_q;
  assign out_o.first_position = POS_PORT_W'(res_first_q);

endmodule

// ===== hdl/cipm_checker.sv =====
module cipm_checker
  import cipm_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input logic                  match_i,
  input logic [POS_PORT_W-1:0] match_position_i,
  input logic [COUNT_W-1:0]    match_count_i,
  input logic                  first_found_i,
  input logic [POS_PORT_W-1:0] first_position_i
);

  // stalled result stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(match_i) &&
      $stable(match_position_i) && $stable(match_count_i))
    else $error("result changed while stalled");

  // a reported match is counted and marks the sequence as found
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && match_i |-> first_found_i && (match_count_i != '0))
    else $error("match without found flag or count");

  // no match gives a zero position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !match_i |-> match_position_i == '0)
    else $error("position without match");

  // found flag and count agree, first position zero until found
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (first_found_i == (match_count_i != '0)) &&
      (first_found_i || (first_position_i == '0)))
    else $error("found flag and count disagree");

endmodule

bind case_insensitive_pattern_match cipm_checker u_cipm_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .match_i          (out_o.match),
  .match_position_i (out_o.match_position),
  .match_count_i    (out_o.match_count),
  .first_found_i    (out_o.first_found),
  .first_position_i (out_o.first_position)
);
